/* rtl/psd_pkg.sv */
// shared constants and defaults for the population standard deviation block
package psd_pkg;

    // work width of the final arithmetic (products wrap modulo 2^64)
    localparam int WORK_W = 64;
    // integer square root of a WORK_W value
    localparam int ROOT_W = WORK_W / 2;

    // fixed result field widths
    localparam int STD_W     = 16;
    localparam int COUNT_W   = 17;
    localparam int OUT_BITS  = STD_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // parameter defaults
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_MAX_SAMPLES = 65536;

endpackage

/* rtl/psd_addsub.sv */
// shared add/subtract unit used by every step of the final computation
module psd_addsub (
    input  logic [psd_pkg::WORK_W-1:0] i_a,
    input  logic [psd_pkg::WORK_W-1:0] i_b,
    input  logic                       i_sub,
    output logic [psd_pkg::WORK_W-1:0] o_sum,
    output logic                       o_carry
);

    logic [psd_pkg::WORK_W-1:0] b_op;
    logic [psd_pkg::WORK_W:0]   full;

    // on subtract, carry out high means a >= b
    assign b_op = i_sub ? ~i_b : i_b;
    assign full = {1'b0, i_a} + {1'b0, b_op} + {{psd_pkg::WORK_W{1'b0}}, i_sub};

    assign o_sum   = full[psd_pkg::WORK_W-1:0];
    assign o_carry = full[psd_pkg::WORK_W];

endmodule

/* rtl/population_std_dev.sv */
// population standard deviation of a stream of signed samples
//
// usage:
//   input stream: one signed sample per request in s_axis tdata, tlast marks
//   the final sample of a set. samples are taken one per cycle while the block
//   is accumulating; count, sum and sum of squares are kept in registers.
//   past MAX_SAMPLES samples in a set, further samples are dropped and the
//   overflow flag of that set's result is raised.
//   output stream: one result request per set, tdata = {count, std_dev},
//   tuser = overflow. the result sits in an output register, so new samples
//   are taken while it waits for the receiver.
//   closing: after the final sample is taken, tready stays low through a
//   flush step for the last accumulate, CNT_W shift-add steps for n*sumsq,
//   SUM_W steps for sum^2, 32 square root steps and 32 divide steps, all on
//   one shared 64-bit adder; the result is written in the closing step.
//   throughput: one sample per cycle inside a set, plus the stall above per set.
//   stall: a result not yet taken holds the closing step of the next set.
//   reset: synchronous, active low; clears accumulators and both valids.
module population_std_dev #(
    parameter int SAMPLE_BITS = psd_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_SAMPLES = psd_pkg::DEF_MAX_SAMPLES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: sample (SAMPLE_BITS, signed), zero padded to bytes
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,   // is_last
    // result stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: std_dev [15:0], sample_count [32:16], zero padding above
    output logic [psd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tuser    // overflow
);

    // widths that follow from the parameters
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int SQ_RAW = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int SQ_W   = (SQ_RAW > psd_pkg::WORK_W) ? psd_pkg::WORK_W : SQ_RAW;
    localparam int CTR_W  = $clog2((SUM_W > psd_pkg::ROOT_W) ? SUM_W : psd_pkg::ROOT_W);
    localparam int WW     = psd_pkg::WORK_W;
    localparam int RW     = psd_pkg::ROOT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FLUSH = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_SQRT  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state, n_state;

    // accumulators
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]         r_sumsq;
    logic [CNT_W-1:0]        r_tally;
    logic                    r_dropped;

    // input stage: square registered before it is accumulated
    logic                          r_p_valid;
    logic signed [SUM_W-1:0]       r_p_ext;
    logic [2*SAMPLE_BITS-1:0]      r_p_sq;

    // iteration registers
    logic [WW-1:0]    r_acc;
    logic [WW-1:0]    r_mcand;
    logic [SUM_W-1:0] r_mplier;
    logic [WW-1:0]    r_root;
    logic [WW-1:0]    r_bit;
    logic [CNT_W-1:0] r_rem;
    logic [RW-1:0]    r_quo;
    logic [CTR_W-1:0] r_cnt;

    // output register
    logic                          r_out_valid;
    logic [psd_pkg::STD_W-1:0]     r_out_std;
    logic [psd_pkg::COUNT_W-1:0]   r_out_count;
    logic                          r_out_ovf;

    // handshakes
    logic accept;
    logic out_take;
    logic out_load;

    // sample decode
    logic signed [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0]        mag;
    logic                          room;

    // sum of squares including the sample still in the input stage
    logic [SQ_W-1:0] sumsq_next;

    // shared unit hookup
    logic [WW-1:0] alu_a;
    logic [WW-1:0] alu_b;
    logic          alu_sub;
    logic [WW-1:0] alu_sum;
    logic          alu_carry;

    // divide trial value and sum magnitude
    logic [CNT_W:0]   trial;
    logic [SUM_W-1:0] smag;
    logic             last_step;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_take = r_out_valid && i_m_axis_tready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    assign raw  = $signed(i_s_axis_tdata[SAMPLE_BITS-1:0]);
    assign mag  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    assign room = (r_tally < CNT_W'(MAX_SAMPLES));

    assign sumsq_next = r_p_valid ? (r_sumsq + SQ_W'(r_p_sq)) : r_sumsq;

    assign smag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign trial = {r_rem, r_root[RW-1]};
    assign last_step = (r_cnt == '0);

    // operand selection for the shared adder
    always_comb begin
        alu_a   = r_acc;
        alu_b   = r_mplier[0] ? r_mcand : '0;
        alu_sub = 1'b0;
        case (r_state)
            S_MUL1: begin
                alu_sub = 1'b0;
            end
            S_MUL2: begin
                alu_sub = 1'b1;
            end
            S_SQRT: begin
                // root and bit never overlap, so root + bit is an or
                alu_b   = r_root | r_bit;
                alu_sub = 1'b1;
            end
            S_DIV: begin
                alu_a   = WW'(trial);
                alu_b   = WW'(r_tally);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    psd_addsub u_addsub (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept && i_s_axis_tlast) begin
                n_state = S_FLUSH;
            end
            S_FLUSH: n_state = S_MUL1;
            S_MUL1:  if (last_step) begin
                n_state = S_MUL2;
            end
            S_MUL2:  if (last_step) begin
                n_state = S_SQRT;
            end
            S_SQRT:  if (last_step) begin
                n_state = S_DIV;
            end
            S_DIV:   if (last_step) begin
                n_state = S_DONE;
            end
            S_DONE:  if (out_load) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_tally     <= '0;
            r_dropped   <= 1'b0;
            r_sum       <= '0;
            r_sumsq     <= '0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= accept && room;

            // tally and drop decision at accept, adds in the next cycle
            if (out_load) begin
                r_tally   <= '0;
                r_dropped <= 1'b0;
            end else if (accept) begin
                if (room) begin
                    r_tally <= r_tally + 1'b1;
                end else begin
                    r_dropped <= 1'b1;
                end
            end

            if (out_load) begin
                r_sum   <= '0;
                r_sumsq <= '0;
            end else if (r_p_valid) begin
                r_sum   <= r_sum + r_p_ext;
                r_sumsq <= sumsq_next;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and iteration registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_ext <= SUM_W'(raw);
            r_p_sq  <= mag * mag;
        end

        r_cnt <= r_cnt - 1'b1;
        case (r_state)
            S_FLUSH: begin
                // n * sumsq: shift-add over the bits of n
                r_acc    <= '0;
                r_mcand  <= WW'(sumsq_next);
                r_mplier <= SUM_W'(r_tally);
                r_cnt    <= CTR_W'(CNT_W - 1);
            end
            S_MUL1: begin
                r_acc    <= alu_sum;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                if (last_step) begin
                    // then subtract sum^2, again by shift-add
                    r_mcand  <= WW'(smag);
                    r_mplier <= smag;
                    r_cnt    <= CTR_W'(SUM_W - 1);
                end
            end
            S_MUL2: begin
                r_acc    <= alu_sum;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                if (last_step) begin
                    r_root <= '0;
                    r_bit  <= WW'(1) << (WW - 2);
                    r_cnt  <= CTR_W'(RW - 1);
                end
            end
            S_SQRT: begin
                // restoring square root, two bits of radicand a step
                if (alu_carry) begin
                    r_acc  <= alu_sum;
                    r_root <= (r_root >> 1) | r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                if (last_step) begin
                    r_rem <= '0;
                    r_cnt <= CTR_W'(RW - 1);
                end
            end
            S_DIV: begin
                // restoring divide of the root by n, one quotient bit a step
                r_rem  <= alu_carry ? alu_sum[CNT_W-1:0] : trial[CNT_W-1:0];
                r_quo  <= {r_quo[RW-2:0], alu_carry};
                r_root <= r_root << 1;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase

        if (out_load) begin
            r_out_std   <= r_quo[psd_pkg::STD_W-1:0];
            r_out_count <= psd_pkg::COUNT_W'(r_tally);
            r_out_ovf   <= r_dropped;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = psd_pkg::OUT_TDATA_W'({r_out_count, r_out_std});
    assign o_m_axis_tuser  = r_out_ovf;

    // a final sample closes the input until the result is written
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("input still open after final sample");

    // the tally never passes the set limit
    a_tally_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally <= CNT_W'(MAX_SAMPLES))
        else $error("sample tally beyond limit");

    // writing a result clears the accumulators and raises the output valid
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_m_axis_tvalid && (r_tally == '0) && !r_dropped))
        else $error("result written without clearing accumulators");

    // a pending add always comes from an accepted sample
    a_pipe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> $past(accept))
        else $error("accumulate without accepted sample");

endmodule

/* tb/population_std_dev_tb.sv */
// self-checking testbench for the population standard deviation block
`timescale 1ns / 1ps

module population_std_dev_tb;
    import psd_pkg::*;

    localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
    localparam int MAX_SAMPLES = DEF_MAX_SAMPLES;
    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam int SETTLE_CYCLES = 200;
    // longest quiet stretch: receiver hold-off plus a closing stall plus idle gaps
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 930;
    // one long receiver hold-off once this many results have been checked
    localparam int HOLD_AFTER    = 40;
    localparam int HOLD_CYCLES   = 800;

    // how the samples of a generated set are spread
    typedef enum int {
        SPREAD_FULL,    // anywhere in the signed range
        SPREAD_NARROW,  // small values around zero
        SPREAD_FLAT,    // one constant value
        SPREAD_RAILS,   // only the two extremes
        SPREAD_OFFSET   // small spread around a random center
    } spread_e;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
        bit                            steady;    // sender and receiver never idle
        bit                            await_all; // wait for every result before offering
    } sample_req_t;

    typedef struct {
        logic [STD_W-1:0]   std_dev;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } std_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tlast = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;

    // samples waiting to be offered, and results still owed by the block
    sample_req_t sample_backlog[$];
    std_result_t awaited_results[$];

    // predicted accumulator state, 64-bit like the block's final arithmetic
    longint unsigned sum_acc;
    longint unsigned square_acc;
    longint unsigned tally_acc;
    bit              dropped_acc;

    sample_req_t in_flight;
    logic        calm_flag = 1'b0;
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          quiet_cycles = 0;

    population_std_dev #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .MAX_SAMPLES(MAX_SAMPLES)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // sample
        .i_s_axis_tlast  (i_s_axis_tlast),   // is_last
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // std_dev, sample_count
        .o_m_axis_tuser  (o_m_axis_tuser)    // overflow
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // bitwise integer square root, floor of sqrt(v)
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // fold one accepted sample into the predicted state; a final sample
    // closes the set, queues its expected result and clears the state
    task automatic fold_sample(input sample_req_t req);
        longint          wide;
        longint unsigned mag;
        longint unsigned n;
        longint unsigned sum_mag;
        longint unsigned spread;
        std_result_t     res;
        wide = req.sample;
        mag  = (wide < 0) ? longint'(-wide) : longint'(wide);
        if (tally_acc < MAX_SAMPLES) begin
            sum_acc    += longint'(wide);
            square_acc += mag * mag;
            tally_acc  += 1;
        end else begin
            // set too long: sample dropped, even a final one
            dropped_acc = 1'b1;
        end
        if (req.last) begin
            n       = tally_acc;
            sum_mag = sum_acc[63] ? -sum_acc : sum_acc;
            spread  = n * square_acc - sum_mag * sum_mag;
            res.std_dev  = STD_W'(floor_root(spread) / n);
            res.count    = COUNT_W'(n);
            res.overflow = dropped_acc;
            awaited_results.push_back(res);
            sum_acc     = 0;
            square_acc  = 0;
            tally_acc   = 0;
            dropped_acc = 1'b0;
        end
    endtask

    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit last,
                               input bit steady, input bit await_all);
        sample_req_t req;
        req.sample    = s;
        req.last      = last;
        req.steady    = steady;
        req.await_all = await_all;
        sample_backlog.push_back(req);
    endtask

    // one whole set; only its first sample can carry the wait-for-results mark
    task automatic queue_set(input int len, input spread_e spread, input bit steady,
                             input bit await_all);
        logic signed [SAMPLE_BITS-1:0] center;
        logic signed [SAMPLE_BITS-1:0] s;
        center = SAMPLE_BITS'($urandom);
        for (int k = 0; k < len; k++) begin
            case (spread)
                SPREAD_FULL:   s = SAMPLE_BITS'($urandom);
                SPREAD_NARROW: s = SAMPLE_BITS'($urandom_range(16)) - SAMPLE_BITS'(8);
                SPREAD_FLAT:   s = center;
                SPREAD_RAILS:  s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                default:       s = center + SAMPLE_BITS'($urandom_range(6)) - SAMPLE_BITS'(3);
            endcase
            push_sample(s, k == len - 1, steady, await_all && k == 0);
        end
    endtask

    // stimulus, reset and end of run
    initial begin
        int placed;
        int len;
        int set_index;

        // single-sample sets at both extremes give a zero deviation
        push_sample(16'sh7FFF, 1'b1, 1'b0, 1'b0);
        push_sample(16'sh8000, 1'b1, 1'b0, 1'b0);
        // the widest possible spread
        push_sample(16'sh8000, 1'b0, 1'b0, 1'b0);
        push_sample(16'sh7FFF, 1'b1, 1'b0, 1'b0);
        // all zero
        push_sample(16'sh0000, 1'b0, 1'b0, 1'b0);
        push_sample(16'sh0000, 1'b0, 1'b0, 1'b0);
        push_sample(16'sh0000, 1'b1, 1'b0, 1'b0);
        // 1..4: variance 1.25, root floors to 1
        push_sample(16'sh0001, 1'b0, 1'b0, 1'b0);
        push_sample(16'sh0002, 1'b0, 1'b0, 1'b0);
        push_sample(16'sh0003, 1'b0, 1'b0, 1'b0);
        push_sample(16'sh0004, 1'b1, 1'b0, 1'b0);
        // two symmetric pairs around zero
        push_sample(-16'sh0005, 1'b0, 1'b0, 1'b0);
        push_sample(16'sh0005, 1'b0, 1'b0, 1'b0);
        push_sample(-16'sh0005, 1'b0, 1'b0, 1'b0);
        push_sample(16'sh0005, 1'b1, 1'b0, 1'b0);
        // alternating bit patterns
        push_sample(16'sh5555, 1'b0, 1'b0, 1'b0);
        push_sample(16'shAAAA, 1'b0, 1'b0, 1'b0);
        push_sample(-16'sh0001, 1'b1, 1'b0, 1'b0);
        // large sum with no spread
        push_sample(16'sh8000, 1'b0, 1'b0, 1'b0);
        push_sample(16'sh8000, 1'b0, 1'b0, 1'b0);
        push_sample(16'sh8000, 1'b1, 1'b0, 1'b0);

        // two long sets streamed with no idling on either side
        queue_set(200, SPREAD_FULL, 1'b1, 1'b1);
        queue_set(100, SPREAD_RAILS, 1'b1, 1'b0);

        // random sets, mostly short
        placed    = 0;
        set_index = 0;
        while (placed < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       len = 1;
                1, 2, 3: len = $urandom_range(60, 25);
                default: len = $urandom_range(24, 2);
            endcase
            // one pause mid-run until every result is back
            queue_set(len, spread_e'($urandom_range(4)), 1'b0, set_index == 15);
            placed    += len;
            set_index += 1;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (sample_backlog.size() != 0 || i_s_axis_tvalid ||
                   awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // sample driver
    always @(posedge i_clk) begin : drive_samples
        bit          moved;
        bit          offer;
        sample_req_t head;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            calm_flag       <= 1'b0;
            sum_acc     = 0;
            square_acc  = 0;
            tally_acc   = 0;
            dropped_acc = 1'b0;
        end else begin
            moved = i_s_axis_tvalid && o_s_axis_tready;
            if (moved) begin
                fold_sample(in_flight);
            end
            // a request that was not taken stays on the bus unchanged
            if (!i_s_axis_tvalid || moved) begin
                offer = 1'b0;
                if (sample_backlog.size() != 0) begin
                    head = sample_backlog[0];
                    if (head.await_all && awaited_results.size() != 0) begin
                        offer = 1'b0;
                    end else if (head.steady) begin
                        offer = 1'b1;
                    end else begin
                        offer = $urandom_range(99) >= 33;
                    end
                end
                if (offer) begin
                    in_flight = sample_backlog.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= IN_TDATA_W'(unsigned'(in_flight.sample));
                    i_s_axis_tlast  <= in_flight.last;
                    calm_flag       <= in_flight.steady;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge i_clk) begin : check_results
        std_result_t want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_checked += 1;
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with nothing expected, std_dev %0d count %0d ovf %0b",
                             $time, o_m_axis_tdata[STD_W-1:0],
                             o_m_axis_tdata[STD_W +: COUNT_W], o_m_axis_tuser);
                    mismatch_count += 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (o_m_axis_tdata[STD_W-1:0] !== want.std_dev) begin
                        $display("%0t: std_dev mismatch, expected %0d, actual %0d", $time,
                                 want.std_dev, o_m_axis_tdata[STD_W-1:0]);
                        mismatch_count += 1;
                    end
                    if (o_m_axis_tdata[STD_W +: COUNT_W] !== want.count) begin
                        $display("%0t: sample_count mismatch, expected %0d, actual %0d",
                                 $time, want.count, o_m_axis_tdata[STD_W +: COUNT_W]);
                        mismatch_count += 1;
                    end
                    if (o_m_axis_tuser !== want.overflow) begin
                        $display("%0t: overflow mismatch, expected %0b, actual %0b", $time,
                                 want.overflow, o_m_axis_tuser);
                        mismatch_count += 1;
                    end
                end
            end
            // one long hold-off so the output register fills and the input stalls
            if (hold_left != 0) begin
                hold_left -= 1;
                i_m_axis_tready <= 1'b0;
            end else if (!hold_done && results_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_m_axis_tready <= 1'b0;
            end else if (calm_flag) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= $urandom_range(99) >= 33;
            end
        end
    end

    // ends the run when no request moves on either side for too long
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no request moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
